FILE: rtl/fenwick_range_sum_top_macros.svh
// Assertion macros shared by the checker files of the range-sum tree.
// Depends on nothing; the including module must provide clk and arst_n.
`ifndef FENWICK_RANGE_SUM_TOP_MACROS_SVH
`define FENWICK_RANGE_SUM_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FRS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FRS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/frs_pkg.sv
// Shared constants, field layout, control structs and helpers of the range-sum tree.
// Depends on nothing; used by the controller, datapath and top level.
package frs_pkg;

	localparam int MAX_ELEMENTS = 1024;
	localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
	localparam int SIZE_W       = ADDR_W + 1;
	localparam int IDX_W        = ADDR_W + 2;
	localparam int DATA_W       = 32;

	localparam int FIRST_LSB    = 0;
	localparam int LAST_LSB     = ADDR_W;
	localparam int DELTA_LSB    = 2 * ADDR_W;
	localparam int S_FIELDS_W   = 2 * ADDR_W + DATA_W;
	localparam int S_TDATA_W    = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int M_TDATA_W    = DATA_W;

	localparam logic CMD_ADD    = 1'b0;
	localparam logic CMD_RANGE  = 1'b1;

	typedef struct packed {
		logic clr_start;
		logic clr_run;
		logic accept;
		logic rd_en;
		logic k_up;
		logic rd_neg;
		logic rd_wr;
		logic load_first;
		logic out_load;
	} frs_cmd_t;

	typedef struct packed {
		logic in_cmd;
		logic in_bad;
		logic k_zero;
		logic k_in;
		logic clr_last;
	} frs_stat_t;

	function automatic logic [IDX_W-1:0] low_bit(input logic [IDX_W-1:0] k);
		return k & (~k + 1'b1);
	endfunction

endpackage

FILE: rtl/frs_ram.sv
// Generic single-write, single-read memory with a registered read port.
// Depends on nothing.
module frs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/frs_dp.sv
// Datapath of the range-sum tree: size register, index walk, accumulator, store.
// Depends on frs_pkg and frs_ram.
module frs_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [frs_pkg::SIZE_W-1:0]    cfg_data,
	input  logic [frs_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                          s_tuser,
	output logic [frs_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                          m_tuser,
	input  frs_pkg::frs_cmd_t             cmd,
	output frs_pkg::frs_stat_t            stat
);

	logic [frs_pkg::SIZE_W-1:0] size_q;
	logic [frs_pkg::SIZE_W-1:0] eff_size;
	logic [frs_pkg::ADDR_W-1:0] clr_addr_q;
	logic [frs_pkg::IDX_W-1:0]  k_q;
	logic [frs_pkg::IDX_W-1:0]  k_dec;
	logic [frs_pkg::IDX_W-1:0]  lb;
	logic [frs_pkg::DATA_W-1:0] acc_q;
	logic [frs_pkg::DATA_W-1:0] delta_q;
	logic [frs_pkg::ADDR_W-1:0] first_q;
	logic                       bad_q;
	logic [frs_pkg::DATA_W-1:0] sum_q;
	logic                       oor_q;
	logic                       rd_pend_s1;
	logic                       rd_neg_s1;
	logic                       rd_wr_s1;
	logic [frs_pkg::ADDR_W-1:0] raddr;
	logic [frs_pkg::ADDR_W-1:0] raddr_s1;
	logic [frs_pkg::DATA_W-1:0] rdata;
	logic                       we;
	logic [frs_pkg::ADDR_W-1:0] waddr;
	logic [frs_pkg::DATA_W-1:0] wdata;
	logic [frs_pkg::ADDR_W-1:0] in_first;
	logic [frs_pkg::ADDR_W-1:0] in_last;
	logic [frs_pkg::DATA_W-1:0] in_delta;

	assign in_first = s_tdata[frs_pkg::FIRST_LSB +: frs_pkg::ADDR_W];
	assign in_last  = s_tdata[frs_pkg::LAST_LSB +: frs_pkg::ADDR_W];
	assign in_delta = s_tdata[frs_pkg::DELTA_LSB +: frs_pkg::DATA_W];

	assign eff_size = (size_q > frs_pkg::SIZE_W'(frs_pkg::MAX_ELEMENTS)) ?
		frs_pkg::SIZE_W'(frs_pkg::MAX_ELEMENTS) : size_q;

	assign lb    = frs_pkg::low_bit(k_q);
	assign k_dec = k_q - 1'b1;
	assign raddr = k_dec[frs_pkg::ADDR_W-1:0];

	always_comb begin
		stat.in_cmd = s_tuser;
		if (s_tuser == frs_pkg::CMD_ADD) begin
			stat.in_bad = ({1'b0, in_first} >= eff_size);
		end else begin
			stat.in_bad = ({1'b0, in_last} >= eff_size) || (in_first > in_last);
		end
		stat.k_zero   = (k_q == '0);
		stat.k_in     = (k_q != '0) && (k_q <= {1'b0, eff_size});
		stat.clr_last = (clr_addr_q == frs_pkg::ADDR_W'(frs_pkg::MAX_ELEMENTS - 1));
	end

	assign we    = cmd.clr_run | (rd_pend_s1 & rd_wr_s1);
	assign waddr = cmd.clr_run ? clr_addr_q : raddr_s1;
	assign wdata = cmd.clr_run ? '0 : rdata + delta_q;

	frs_ram #(
		.WIDTH(frs_pkg::DATA_W),
		.DEPTH(frs_pkg::MAX_ELEMENTS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q     <= frs_pkg::SIZE_W'(frs_pkg::MAX_ELEMENTS);
			clr_addr_q <= '0;
			rd_pend_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				size_q <= cfg_data;
			end
			if (cmd.clr_start) begin
				clr_addr_q <= '0;
			end else if (cmd.clr_run) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			rd_pend_s1 <= cmd.rd_en;
		end
	end

	always_ff @(posedge clk) begin
		rd_neg_s1 <= cmd.rd_neg;
		rd_wr_s1  <= cmd.rd_wr;
		raddr_s1  <= raddr;
		if (cmd.accept) begin
			first_q <= in_first;
			delta_q <= in_delta;
			bad_q   <= stat.in_bad;
			acc_q   <= '0;
			if (s_tuser == frs_pkg::CMD_ADD) begin
				k_q <= frs_pkg::IDX_W'(in_first) + 1'b1;
			end else begin
				k_q <= frs_pkg::IDX_W'(in_last) + 1'b1;
			end
		end else begin
			if (rd_pend_s1 && !rd_wr_s1) begin
				acc_q <= rd_neg_s1 ? acc_q - rdata : acc_q + rdata;
			end
			if (cmd.load_first) begin
				k_q <= frs_pkg::IDX_W'(first_q);
			end else if (cmd.rd_en) begin
				k_q <= cmd.k_up ? k_q + lb : k_q - lb;
			end
		end
		if (cmd.out_load) begin
			sum_q <= acc_q;
			oor_q <= bad_q;
		end
	end

	assign m_tdata = sum_q;
	assign m_tuser = oor_q;

endmodule

FILE: rtl/frs_ctrl.sv
// Controller of the range-sum tree: clearing pass, update walk, two prefix walks.
// Depends on frs_pkg; drives the datapath through frs_cmd_t.
module frs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	input  frs_pkg::frs_stat_t stat,
	output frs_pkg::frs_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ADD,
		S_SUM_HI,
		S_SUM_LO,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   m_tvalid_q;
	logic   out_free;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		cmd.accept = s_tvalid && (state_q == S_IDLE);
		case (state_q)
			S_CLEAR: begin
				cmd.clr_run = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (s_tvalid) begin
					if (stat.in_bad) begin
						state_d = S_DONE;
					end else if (stat.in_cmd == frs_pkg::CMD_ADD) begin
						state_d = S_ADD;
					end else begin
						state_d = S_SUM_HI;
					end
				end
			end
			S_ADD: begin
				if (stat.k_in) begin
					cmd.rd_en = 1'b1;
					cmd.k_up  = 1'b1;
					cmd.rd_wr = 1'b1;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SUM_HI: begin
				if (!stat.k_zero) begin
					cmd.rd_en = 1'b1;
				end else begin
					cmd.load_first = 1'b1;
					state_d        = S_SUM_LO;
				end
			end
			S_SUM_LO: begin
				if (!stat.k_zero) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_neg = 1'b1;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
		if (cfg_we) begin
			cmd.clr_start = 1'b1;
			cmd.clr_run   = 1'b0;
			state_d       = S_CLEAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/fenwick_range_sum_top.sv
// Top level of the binary indexed range-sum tree over 1024 signed 32-bit partial sums.
// Depends on frs_pkg, frs_ctrl, frs_dp and frs_ram.
//
// The slave stream takes one command per beat: s_tuser is the command (add or range
// sum), s_tdata carries first, last and delta. The master stream returns one beat per
// command: m_tdata is the wrapping sum (zero for an add) and m_tuser flags a position
// or bound out of range or a first above last; the command then did nothing.
// The cfg channel writes the active size; it is always ready and should only be used
// while no command is in flight.
// After reset, and after every size write, a clearing pass zeroes all 1024 words of the
// store, during which s_tready is low.
// One command is worked at a time, one store read per tree node. A flagged command
// goes straight to the result register; an add first adds delta along its upward walk,
// a range query first adds the prefix through last and subtracts the one below first.
// The result sits in an output register; while the receiver stalls, the next command
// is still accepted and worked, and waits only to load its result.
module fenwick_range_sum_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// first [9:0], last [19:10], delta [51:20], zero fill [55:52]
	input  logic [frs_pkg::S_TDATA_W-1:0] s_tdata,
	// cmd [0]
	input  logic [0:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// sum [31:0]
	output logic [frs_pkg::M_TDATA_W-1:0] m_tdata,
	// out_of_range [0]
	output logic [0:0]                    m_tuser,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [frs_pkg::SIZE_W-1:0]    cfg_data
);

	frs_pkg::frs_cmd_t  cmd;
	frs_pkg::frs_stat_t stat;
	logic               cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid & cfg_ready;

	frs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	frs_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser[0]),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser[0]),
		.cmd     (cmd),
		.stat    (stat)
	);

endmodule

FILE: rtl/frs_checker.sv
// Port-level checker of the range-sum tree and its bind to the top level.
// Depends on fenwick_range_sum_top_macros.svh and frs_pkg.
`include "fenwick_range_sum_top_macros.svh"

module frs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [frs_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [0:0]                    m_tuser,
	input logic                          cfg_valid,
	input logic                          cfg_ready
);

	`FRS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "Stalled result beat changed.")
	`FRS_ASSERT_NOW(a_flag_zero, m_tvalid && m_tuser[0], m_tdata == '0, "Flagged result carries a nonzero sum.")
	`FRS_ASSERT_NOW(a_cfg_taken, cfg_valid, cfg_ready, "Size write was not taken.")
	`FRS_ASSERT_NEXT(a_cfg_clears, cfg_valid && cfg_ready, !s_tready, "Command accepted during the clearing pass.")

endmodule

bind fenwick_range_sum_top frs_checker u_frs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.cfg_valid(cfg_valid),
	.cfg_ready(cfg_ready)
);

FILE: dv/fenwick_range_sum_top_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for fenwick_range_sum_top: a directed table of commands and size writes,
// then random add and range commands over several active sizes, with bursty input and stalls.
// Depends on frs_pkg and the fenwick_range_sum_top RTL; checked by an in-bench tree or the table.
module fenwick_range_sum_top_tb;
	import frs_pkg::*;

	localparam int STALL_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 30;
	localparam int LONG_HOLD    = 400;
	localparam int ROWS         = 24;
	localparam int PHASES       = 8;

	typedef struct packed {
		logic [DATA_W-1:0] sum;
		logic              bad;
	} tree_result_t;

	typedef struct packed {
		logic              is_cfg;
		logic [SIZE_W-1:0] size;
		logic              cmd;
		logic [ADDR_W-1:0] first;
		logic [ADDR_W-1:0] last;
		logic [DATA_W-1:0] delta;
		logic              known;
		logic [DATA_W-1:0] exp_sum;
		logic              exp_bad;
	} step_row_t;

	localparam step_row_t DIRECTED_ROWS [ROWS] = '{
		'{1'b0, 11'd0,    CMD_RANGE, 10'd0,    10'd1023, 32'h0,        1'b1, 32'h0, 1'b0},
		'{1'b0, 11'd0,    CMD_ADD,   10'd0,    10'd0,    32'h7FFFFFFF, 1'b1, 32'h0, 1'b0},
		'{1'b0, 11'd0,    CMD_ADD,   10'd1023, 10'd0,    32'h80000000, 1'b1, 32'h0, 1'b0},
		'{1'b0, 11'd0,    CMD_RANGE, 10'd0,    10'd1023, 32'h0,        1'b0, 32'h0, 1'b0},
		'{1'b0, 11'd0,    CMD_RANGE, 10'd1023, 10'd1023, 32'h0,        1'b0, 32'h0, 1'b0},
		'{1'b0, 11'd0,    CMD_RANGE, 10'd0,    10'd0,    32'h0,        1'b0, 32'h0, 1'b0},
		'{1'b0, 11'd0,    CMD_RANGE, 10'd600,  10'd5,    32'h0,        1'b1, 32'h0, 1'b1},
		'{1'b0, 11'd0,    CMD_ADD,   10'd512,  10'd0,    32'hFFFFFFFF, 1'b1, 32'h0, 1'b0},
		'{1'b0, 11'd0,    CMD_RANGE, 10'd1,    10'd1022, 32'h0,        1'b0, 32'h0, 1'b0},
		'{1'b0, 11'd0,    CMD_ADD,   10'd341,  10'd1023, 32'h12345678, 1'b1, 32'h0, 1'b0},
		'{1'b1, 11'd3,    CMD_ADD,   10'd0,    10'd0,    32'h0,        1'b0, 32'h0, 1'b0},
		'{1'b0, 11'd0,    CMD_RANGE, 10'd0,    10'd2,    32'h0,        1'b1, 32'h0, 1'b0},
		'{1'b0, 11'd0,    CMD_ADD,   10'd2,    10'd0,    32'h5,        1'b1, 32'h0, 1'b0},
		'{1'b0, 11'd0,    CMD_ADD,   10'd3,    10'd0,    32'h9,        1'b1, 32'h0, 1'b1},
		'{1'b0, 11'd0,    CMD_RANGE, 10'd0,    10'd3,    32'h0,        1'b1, 32'h0, 1'b1},
		'{1'b0, 11'd0,    CMD_RANGE, 10'd2,    10'd2,    32'h0,        1'b0, 32'h0, 1'b0},
		'{1'b0, 11'd0,    CMD_RANGE, 10'd0,    10'd2,    32'h0,        1'b0, 32'h0, 1'b0},
		'{1'b1, 11'd0,    CMD_ADD,   10'd0,    10'd0,    32'h0,        1'b0, 32'h0, 1'b0},
		'{1'b0, 11'd0,    CMD_ADD,   10'd0,    10'd0,    32'h1,        1'b1, 32'h0, 1'b1},
		'{1'b0, 11'd0,    CMD_RANGE, 10'd0,    10'd0,    32'h0,        1'b1, 32'h0, 1'b1},
		'{1'b1, 11'd2047, CMD_ADD,   10'd0,    10'd0,    32'h0,        1'b0, 32'h0, 1'b0},
		'{1'b0, 11'd0,    CMD_ADD,   10'd1023, 10'd0,    32'h7FFFFFFF, 1'b1, 32'h0, 1'b0},
		'{1'b0, 11'd0,    CMD_RANGE, 10'd1023, 10'd1023, 32'h0,        1'b0, 32'h0, 1'b0},
		'{1'b0, 11'd0,    CMD_RANGE, 10'd0,    10'd1023, 32'h0,        1'b0, 32'h0, 1'b0}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [0:0]           s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [0:0]           m_tuser;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [SIZE_W-1:0]    cfg_data;

	logic [DATA_W-1:0] node_sum [MAX_ELEMENTS];
	logic [SIZE_W-1:0] size_in_use;
	tree_result_t      pending_results [$];
	int                mismatch_count;
	int                quiet_cycles;
	int                hold_asks;
	int                burst_left;
	bit                gaps_on;

	fenwick_range_sum_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [DATA_W-1:0] prefix_sum(input int k);
		logic [DATA_W-1:0] acc;
		acc = '0;
		while (k > 0) begin
			acc += node_sum[k-1];
			k -= k & -k;
		end
		return acc;
	endfunction

	function automatic tree_result_t tree_step(input logic cmd, input logic [ADDR_W-1:0] first,
			input logic [ADDR_W-1:0] last, input logic [DATA_W-1:0] delta);
		tree_result_t res;
		int span;
		int k;
		res = '0;
		span = (size_in_use > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(size_in_use);
		if (cmd == CMD_ADD) begin
			if (int'(first) >= span) begin
				res.bad = 1'b1;
			end else begin
				k = int'(first) + 1;
				while (k <= span) begin
					node_sum[k-1] += delta;
					k += k & -k;
				end
			end
		end else if (int'(last) >= span || first > last) begin
			res.bad = 1'b1;
		end else begin
			res.sum = prefix_sum(int'(last) + 1) - prefix_sum(int'(first));
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		$display("ERROR %s: got %h, expected %h at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	task automatic hold_sender();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	task automatic send_command(input logic cmd, input logic [ADDR_W-1:0] first,
			input logic [ADDR_W-1:0] last, input logic [DATA_W-1:0] delta,
			input bit known, input tree_result_t typed);
		tree_result_t res;
		int gap;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= S_TDATA_W'({delta, last, first});
		do @(posedge clk); while (!s_tready);
		res = tree_step(cmd, first, last, delta);
		pending_results.push_back(known ? typed : res);
		if (gaps_on) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				gap = $urandom_range(1, 12);
				repeat (gap) begin
					@(negedge clk);
					s_tvalid <= 1'b0;
				end
				burst_left = $urandom_range(0, 15);
			end
		end
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_size(input logic [SIZE_W-1:0] value);
		hold_sender();
		wait_drained();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		size_in_use = value;
		foreach (node_sum[i]) node_sum[i] = '0;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_command();
		int span;
		int pick;
		logic cmd;
		logic [ADDR_W-1:0] a;
		logic [ADDR_W-1:0] b;
		logic [ADDR_W-1:0] t;
		logic [DATA_W-1:0] d;
		span = (size_in_use > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(size_in_use);
		pick = $urandom_range(0, 99);
		cmd = 1'($urandom_range(0, 1));
		a = ADDR_W'($urandom_range(0, MAX_ELEMENTS - 1));
		b = ADDR_W'($urandom_range(0, MAX_ELEMENTS - 1));
		if (span > 0 && pick < 55) begin
			cmd = CMD_ADD;
			a = ADDR_W'($urandom_range(0, span - 1));
		end else if (span > 0 && pick < 90) begin
			cmd = CMD_RANGE;
			a = ADDR_W'($urandom_range(0, span - 1));
			b = ADDR_W'($urandom_range(0, span - 1));
			if (a > b) begin
				t = a;
				a = b;
				b = t;
			end
		end
		case ($urandom_range(0, 7))
			0: d = 32'h80000000;
			1: d = 32'h7FFFFFFF;
			2, 3: d = DATA_W'($signed($urandom_range(0, 16)) - 8);
			default: d = $urandom;
		endcase
		send_command(cmd, a, b, d, 1'b0, '0);
	endtask

	initial begin : result_sink
		int cyc;
		int seen;
		int i;
		cyc = 0;
		seen = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_asks != seen) begin
				seen = hold_asks;
				m_tready <= 1'b0;
				for (i = 1; i < LONG_HOLD; i++) begin
					@(negedge clk);
					m_tready <= 1'b0;
				end
			end else begin
				cyc++;
				case ((cyc / 100) % 3)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 9) >= 3);
					default: m_tready <= ((cyc % 7) < 4);
				endcase
			end
		end
	end

	always @(posedge clk) begin : result_check
		tree_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result beat", m_tdata, '0);
				end else begin
					want = pending_results.pop_front();
					if (m_tdata !== want.sum)
						report_mismatch("sum", m_tdata, want.sum);
					if (m_tuser[0] !== want.bad)
						report_mismatch("out_of_range", DATA_W'(m_tuser), DATA_W'(want.bad));
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [SIZE_W-1:0] phase_sizes [PHASES];
		tree_result_t typed;
		int n;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		mismatch_count = 0;
		quiet_cycles = 0;
		hold_asks = 0;
		burst_left = 0;
		gaps_on = 1'b1;
		size_in_use = SIZE_W'(MAX_ELEMENTS);
		foreach (node_sum[i]) node_sum[i] = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (n = 0; n < ROWS; n++) begin
			if (DIRECTED_ROWS[n].is_cfg) begin
				write_size(DIRECTED_ROWS[n].size);
			end else begin
				typed.sum = DIRECTED_ROWS[n].exp_sum;
				typed.bad = DIRECTED_ROWS[n].exp_bad;
				send_command(DIRECTED_ROWS[n].cmd, DIRECTED_ROWS[n].first,
					DIRECTED_ROWS[n].last, DIRECTED_ROWS[n].delta,
					DIRECTED_ROWS[n].known, typed);
			end
		end

		phase_sizes = '{11'd1024, 11'd1, 11'd2047, 11'd0, 11'd1025, 11'd0, 11'd0, 11'd1024};
		phase_sizes[5] = SIZE_W'($urandom_range(2, MAX_ELEMENTS - 1));
		phase_sizes[6] = SIZE_W'($urandom_range(2, 64));
		for (n = 0; n < PHASES; n++) begin
			write_size(phase_sizes[n]);
			if (n == 0) begin
				// Keep offering commands while the result side is held off.
				gaps_on = 1'b0;
				hold_asks++;
				repeat (40) random_command();
				hold_sender();
				wait_drained();
			end
			gaps_on = (n % 3 != 2);
			repeat (60) random_command();
		end

		hold_sender();
		wait_drained();
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/frs_pkg.sv
rtl/frs_ram.sv
rtl/frs_dp.sv
rtl/frs_ctrl.sv
rtl/fenwick_range_sum_top.sv
rtl/frs_checker.sv
dv/fenwick_range_sum_top_tb.sv
